// File: rtl/nbeg_pkg.sv
// Shared types, constants and helper functions of the n-body gravity step block.
package nbeg_pkg;

    // Default table depth and configuration reset values.
    localparam int unsigned BODY_SLOTS_DEF = 16;
    localparam logic [23:0] GRAV_RESET     = 24'd398600;
    localparam logic [9:0]  KPP_RESET      = 10'd100;
    localparam logic [15:0] DMIN_RESET     = 16'd5;

    // Width of the shared divider and root units.
    localparam int unsigned DIV_W = 64;

    // Configuration register indexes (byte address divided by four).
    localparam logic [1:0] REG_GRAV = 2'd0;
    localparam logic [1:0] REG_KPP  = 2'd1;
    localparam logic [1:0] REG_DMIN = 2'd2;

    // Input action codes.
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_SPAWN = 1'b1;

    // Result status codes.
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    // One entry of the body table.
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [19:0] mass;
    } body_t;

    // Configuration register set as seen by the datapath.
    typedef struct packed {
        logic [23:0] grav;
        logic [9:0]  kpp;
        logic [15:0] dmin;
    } cfg_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SPAWN,
        ST_I_CHECK,
        ST_I_LOAD,
        ST_J_CHECK,
        ST_J_LOAD,
        ST_SCALE,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_ACC_GO,
        ST_ACC_WAIT,
        ST_CX_GO,
        ST_CX_WAIT,
        ST_CY_GO,
        ST_CY_WAIT,
        ST_DV_MUL,
        ST_DV_ADD,
        ST_I_WB,
        ST_M_CHECK,
        ST_M_LOAD,
        ST_MX_GO,
        ST_MX_WAIT,
        ST_MY_GO,
        ST_MY_WAIT,
        ST_M_WB,
        ST_OUT
    } state_t;

    // Magnitude of a signed 32-bit value.
    function automatic logic [31:0] umag32(input logic [31:0] v);
        logic [31:0] res;
        res = v[31] ? (~v + 32'd1) : v;
        return res;
    endfunction

    // Adds a signed step given as magnitude and sign, saturating to signed 32 bits.
    function automatic logic [31:0] sat_add(input logic [31:0] base, input logic [39:0] mag,
                                            input logic neg);
        logic signed [41:0] m;
        logic signed [41:0] s;
        logic [31:0]        res;
        m = $signed({2'b00, mag});
        if (neg) begin
            m = -m;
        end
        s = $signed({{10{base[31]}}, base}) + m;
        if (s > 42'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (s < -42'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = s[31:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/nbeg_div.sv
// Restoring divider that produces one quotient bit per cycle.
module nbeg_div
    import nbeg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int unsigned CW = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W:0]   shifted;
    logic             take;

    // Shift in the next dividend bit and try the subtraction.
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign take    = (shifted >= {1'b0, den_reg});

    // Control: busy until the counter reaches DIV_W - 1, then a one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            if (take) begin
                rem_reg <= DIV_W'(shifted - {1'b0, den_reg});
            end else begin
                rem_reg <= shifted[DIV_W-1:0];
            end
            quo_reg <= {quo_reg[DIV_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/nbeg_sqrt.sv
// Integer square root unit that settles two radicand bits per cycle.
module nbeg_sqrt
    import nbeg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] radicand,
    output logic             done,
    output logic [DIV_W/2-1:0] root
);

    localparam int unsigned STEPS = DIV_W / 2;
    localparam int unsigned CW    = $clog2(STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] res_reg;
    logic [DIV_W-1:0] bit_reg;
    logic [DIV_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    // Control: STEPS iterations, then a one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Digit-by-digit root: compare against result plus the current bit.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= radicand;
            res_reg <= '0;
            bit_reg <= {2'b01, {(DIV_W-2){1'b0}}};
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[DIV_W/2-1:0];

endmodule

// File: rtl/nbeg_body_mem.sv
// Body table memory with one write port and one registered read port.
module nbeg_body_mem
    import nbeg_pkg::*;
#(
    parameter int unsigned BODY_SLOTS = BODY_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(BODY_SLOTS)-1:0] waddr,
    input  body_t                         wdata,
    input  logic                          re,
    input  logic [$clog2(BODY_SLOTS)-1:0] raddr,
    output body_t                         rdata
);

    body_t mem [BODY_SLOTS];
    body_t rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/nbeg_cfg.sv
// APB configuration registers: gravity constant, scale and minimum distance.
module nbeg_cfg
    import nbeg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [23:0] grav_reg;
    logic [9:0]  kpp_reg;
    logic [15:0] dmin_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Register writes during the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg <= GRAV_RESET;
            kpp_reg  <= KPP_RESET;
            dmin_reg <= DMIN_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_GRAV: grav_reg <= pwdata[23:0];
                REG_KPP:  kpp_reg  <= pwdata[9:0];
                REG_DMIN: dmin_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (paddr[3:2])
            REG_GRAV: prdata = {8'd0, grav_reg};
            REG_KPP:  prdata = {22'd0, kpp_reg};
            REG_DMIN: prdata = {16'd0, dmin_reg};
            default:  prdata = 32'd0;
        endcase
    end

    assign cfg = '{grav: grav_reg, kpp: kpp_reg, dmin: dmin_reg};

endmodule

// File: rtl/nbody_gravity_euler_step_top.sv
// Top level of the 2D direct-sum gravity block with semi-implicit Euler steps.
//
// Input transactions on s_* carry an action. A spawn stores the body in the
// lowest free slot and returns one transaction with that slot, or status 1
// when the table is full. A tick with step s_dt returns one transaction per
// slot, in slot order, with m_last on the final one.
// A spawn passes through ST_SPAWN and offers its result in ST_OUT.
// A tick runs pair by pair from the body memory through one shared
// serial root unit and one shared serial divider, with three divider uses
// per ordered pair of active bodies. One item is worked at a time;
// s_ready is high only between items. A stalled m_ready holds the result
// register and freezes the sequencer until the transaction completes.
// Reset clears the slot-used bits, the configuration registers to their
// defaults and the sequencer; the body memory needs no clearing since
// only used slots are ever read. Configuration must be written over the
// APB port only while the block is idle; the block itself does not
// enforce this.
module nbody_gravity_euler_step_top
    import nbeg_pkg::*;
#(
    parameter int unsigned BODY_SLOTS = BODY_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [23:0] s_dt,
    input  logic [31:0] s_in_pos_x,
    input  logic [31:0] s_in_pos_y,
    input  logic [31:0] s_in_vel_x,
    input  logic [31:0] s_in_vel_y,
    input  logic [19:0] s_in_mass,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_slot,
    output logic        m_active,
    output logic [31:0] m_out_pos_x,
    output logic [31:0] m_out_pos_y,
    output logic        m_status,
    output logic        m_last
);

    localparam int unsigned IW = $clog2(BODY_SLOTS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(BODY_SLOTS - 1);

    cfg_t   cfg;
    state_t state_reg, state_next;

    // Effective configuration: zero means one.
    logic [9:0]  kpp_eff;
    logic [15:0] dmin_eff;
    assign kpp_eff  = (cfg.kpp == 10'd0) ? 10'd1 : cfg.kpp;
    assign dmin_eff = (cfg.dmin == 16'd0) ? 16'd1 : cfg.dmin;

    // Captured input transaction.
    logic [23:0] dt_reg;
    body_t       spawn_reg;

    // Slot occupancy and loop indexes.
    logic [BODY_SLOTS-1:0] used_reg;
    logic [IW-1:0]         i_reg;
    logic [IW-1:0]         j_reg;

    // Pair datapath registers.
    body_t        cur_reg;
    logic [31:0]  vx_acc_reg, vy_acc_reg;
    logic [31:0]  magx_reg, magy_reg;
    logic         negx_reg, negy_reg;
    logic [43:0]  gm_reg;
    logic [25:0]  ax_reg, ay_reg;
    logic [51:0]  ax2_reg, ay2_reg;
    logic [26:0]  r_reg;
    logic [30:0]  acc_reg;
    logic [30:0]  cx_reg, cy_reg;
    logic [54:0]  dpx_reg, dpy_reg;
    logic [31:0]  newx_reg, newy_reg;

    // Result register.
    logic        m_valid_reg;
    logic [3:0]  m_slot_reg;
    logic        m_active_reg;
    logic [31:0] m_pos_x_reg, m_pos_y_reg;
    logic        m_status_reg;
    logic        m_last_reg;

    // Memory and shared unit hookups.
    logic             mem_we, mem_re;
    logic [IW-1:0]    mem_waddr, mem_raddr;
    body_t            mem_wdata, mem_rdata;
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_dividend, div_divisor, div_q;
    logic             sqrt_start, sqrt_done;
    logic [DIV_W/2-1:0] sqrt_root;
    logic [DIV_W-1:0] sqrt_rad;

    // Lowest free slot.
    logic          free_found;
    logic [IW-1:0] free_idx;
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int n = BODY_SLOTS - 1; n >= 0; n--) begin
            if (!used_reg[n]) begin
                free_found = 1'b1;
                free_idx   = IW'(n);
            end
        end
    end

    // Slot number masked to the four bits of the result field.
    logic [IW+3:0] slot_ext;
    assign slot_ext = {4'd0, i_reg};

    // Spawned slot number masked to four bits.
    function automatic logic [3:0] slot_ext_spawn(input logic [IW-1:0] idx);
        logic [IW+3:0] ext;
        ext = {4'd0, idx};
        return ext[3:0];
    endfunction

    logic [33:0] diff_x, diff_y;
    logic [41:0] sx_prod, sy_prod;
    logic [55:0] mv_prod;
    logic [31:0] mag_v;

    assign diff_x  = {{2{mem_rdata.x[31]}}, mem_rdata.x} - {{2{cur_reg.x[31]}}, cur_reg.x};
    assign diff_y  = {{2{mem_rdata.y[31]}}, mem_rdata.y} - {{2{cur_reg.y[31]}}, cur_reg.y};
    assign sx_prod = magx_reg * kpp_eff;
    assign sy_prod = magy_reg * kpp_eff;
    assign mag_v   = (state_reg == ST_MX_GO) ? umag32(cur_reg.vx) : umag32(cur_reg.vy);
    assign mv_prod = mag_v * dt_reg;

    nbeg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nbeg_body_mem #(.BODY_SLOTS(BODY_SLOTS)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    nbeg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    nbeg_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_action == ACT_SPAWN) ? ST_SPAWN : ST_I_CHECK;
                end
            end
            ST_SPAWN:     state_next = ST_OUT;
            ST_I_CHECK: begin
                if (used_reg[i_reg]) begin
                    state_next = ST_I_LOAD;
                end else if (i_reg == LAST_SLOT) begin
                    state_next = ST_M_CHECK;
                end
            end
            ST_I_LOAD:    state_next = ST_J_CHECK;
            ST_J_CHECK: begin
                if (used_reg[j_reg] && (j_reg != i_reg)) begin
                    state_next = ST_J_LOAD;
                end else if (j_reg == LAST_SLOT) begin
                    state_next = ST_I_WB;
                end
            end
            ST_J_LOAD:    state_next = ST_SCALE;
            ST_SCALE:     state_next = ST_SQUARE;
            ST_SQUARE:    state_next = ST_ROOT_GO;
            ST_ROOT_GO:   state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT: if (sqrt_done) state_next = ST_ACC_GO;
            ST_ACC_GO:    state_next = ST_ACC_WAIT;
            ST_ACC_WAIT:  if (div_done) state_next = ST_CX_GO;
            ST_CX_GO:     state_next = ST_CX_WAIT;
            ST_CX_WAIT:   if (div_done) state_next = ST_CY_GO;
            ST_CY_GO:     state_next = ST_CY_WAIT;
            ST_CY_WAIT:   if (div_done) state_next = ST_DV_MUL;
            ST_DV_MUL:    state_next = ST_DV_ADD;
            ST_DV_ADD:    state_next = (j_reg == LAST_SLOT) ? ST_I_WB : ST_J_CHECK;
            ST_I_WB:      state_next = (i_reg == LAST_SLOT) ? ST_M_CHECK : ST_I_CHECK;
            ST_M_CHECK:   state_next = used_reg[i_reg] ? ST_M_LOAD : ST_OUT;
            ST_M_LOAD:    state_next = ST_MX_GO;
            ST_MX_GO:     state_next = ST_MX_WAIT;
            ST_MX_WAIT:   if (div_done) state_next = ST_MY_GO;
            ST_MY_GO:     state_next = ST_MY_WAIT;
            ST_MY_WAIT:   if (div_done) state_next = ST_M_WB;
            ST_M_WB:      state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = m_last_reg ? ST_IDLE : ST_M_CHECK;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Output decode: memory port, shared units and handshake.
    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = i_reg;
        mem_wdata    = cur_reg;
        mem_re       = 1'b0;
        mem_raddr    = i_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = DIV_W'(1);
        sqrt_start   = 1'b0;
        sqrt_rad     = DIV_W'(ax2_reg) + DIV_W'(ay2_reg);
        unique case (state_reg) inside
            ST_SPAWN: begin
                mem_we    = free_found;
                mem_waddr = free_idx;
                mem_wdata = spawn_reg;
            end
            ST_I_CHECK, ST_M_CHECK: begin
                mem_re    = used_reg[i_reg];
                mem_raddr = i_reg;
            end
            ST_J_CHECK: begin
                mem_re    = used_reg[j_reg] && (j_reg != i_reg);
                mem_raddr = j_reg;
            end
            ST_ROOT_GO: sqrt_start = 1'b1;
            ST_ACC_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({gm_reg, 16'd0});
                div_divisor  = DIV_W'(r_reg * r_reg);
            end
            ST_CX_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(acc_reg * ax_reg);
                div_divisor  = DIV_W'(r_reg);
            end
            ST_CY_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(acc_reg * ay_reg);
                div_divisor  = DIV_W'(r_reg);
            end
            ST_I_WB: begin
                mem_we    = 1'b1;
                mem_wdata = '{x: cur_reg.x, y: cur_reg.y, vx: vx_acc_reg, vy: vy_acc_reg,
                              mass: cur_reg.mass};
            end
            ST_MX_GO, ST_MY_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(mv_prod[55:16]);
                div_divisor  = DIV_W'(kpp_eff);
            end
            ST_M_WB: begin
                mem_we    = 1'b1;
                mem_wdata = '{x: newx_reg, y: newy_reg, vx: cur_reg.vx, vy: cur_reg.vy,
                              mass: cur_reg.mass};
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Control registers: state, occupancy, indexes and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    i_reg <= '0;
                end
                ST_SPAWN: begin
                    if (free_found) begin
                        used_reg[free_idx] <= 1'b1;
                    end
                    m_valid_reg <= 1'b1;
                end
                ST_I_CHECK: begin
                    if (!used_reg[i_reg]) begin
                        i_reg <= (i_reg == LAST_SLOT) ? '0 : i_reg + IW'(1);
                    end
                end
                ST_I_LOAD: j_reg <= '0;
                ST_J_CHECK: begin
                    if (!(used_reg[j_reg] && (j_reg != i_reg)) && (j_reg != LAST_SLOT)) begin
                        j_reg <= j_reg + IW'(1);
                    end
                end
                ST_DV_ADD: begin
                    if (j_reg != LAST_SLOT) begin
                        j_reg <= j_reg + IW'(1);
                    end
                end
                ST_I_WB: i_reg <= (i_reg == LAST_SLOT) ? '0 : i_reg + IW'(1);
                ST_M_CHECK: begin
                    if (!used_reg[i_reg]) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                ST_M_WB: m_valid_reg <= 1'b1;
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        i_reg       <= i_reg + IW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg) inside
            ST_IDLE: begin
                if (s_valid) begin
                    dt_reg         <= s_dt;
                    spawn_reg.x    <= s_in_pos_x;
                    spawn_reg.y    <= s_in_pos_y;
                    spawn_reg.vx   <= s_in_vel_x;
                    spawn_reg.vy   <= s_in_vel_y;
                    spawn_reg.mass <= s_in_mass;
                end
            end
            ST_SPAWN: begin
                m_slot_reg   <= free_found ? slot_ext_spawn(free_idx) : 4'd0;
                m_active_reg <= free_found;
                m_pos_x_reg  <= free_found ? spawn_reg.x : 32'd0;
                m_pos_y_reg  <= free_found ? spawn_reg.y : 32'd0;
                m_status_reg <= free_found ? STAT_OK : STAT_FULL;
                m_last_reg   <= 1'b1;
            end
            ST_I_LOAD, ST_M_LOAD: begin
                cur_reg    <= mem_rdata;
                vx_acc_reg <= mem_rdata.vx;
                vy_acc_reg <= mem_rdata.vy;
            end
            ST_J_LOAD: begin
                negx_reg <= diff_x[33];
                negy_reg <= diff_y[33];
                magx_reg <= diff_x[33] ? 32'(~diff_x + 34'd1) : diff_x[31:0];
                magy_reg <= diff_y[33] ? 32'(~diff_y + 34'd1) : diff_y[31:0];
                gm_reg   <= cfg.grav * mem_rdata.mass;
            end
            ST_SCALE: begin
                ax_reg <= sx_prod[41:16];
                ay_reg <= sy_prod[41:16];
            end
            ST_SQUARE: begin
                ax2_reg <= ax_reg * ax_reg;
                ay2_reg <= ay_reg * ay_reg;
            end
            ST_ROOT_WAIT: begin
                if (sqrt_done) begin
                    r_reg <= (sqrt_root < 32'(dmin_eff)) ? 27'(dmin_eff) : sqrt_root[26:0];
                end
            end
            ST_ACC_WAIT: begin
                if (div_done) begin
                    acc_reg <= (div_q[DIV_W-1:31] != '0) ? '1 : div_q[30:0];
                end
            end
            ST_CX_WAIT: if (div_done) cx_reg <= div_q[30:0];
            ST_CY_WAIT: if (div_done) cy_reg <= div_q[30:0];
            ST_DV_MUL: begin
                dpx_reg <= cx_reg * dt_reg;
                dpy_reg <= cy_reg * dt_reg;
            end
            ST_DV_ADD: begin
                vx_acc_reg <= sat_add(vx_acc_reg, {1'b0, dpx_reg[54:16]}, negx_reg);
                vy_acc_reg <= sat_add(vy_acc_reg, {1'b0, dpy_reg[54:16]}, negy_reg);
            end
            ST_M_CHECK: begin
                if (!used_reg[i_reg]) begin
                    m_slot_reg   <= slot_ext[3:0];
                    m_active_reg <= 1'b0;
                    m_pos_x_reg  <= 32'd0;
                    m_pos_y_reg  <= 32'd0;
                    m_status_reg <= STAT_OK;
                    m_last_reg   <= (i_reg == LAST_SLOT);
                end
            end
            ST_MX_WAIT: begin
                if (div_done) begin
                    newx_reg <= sat_add(cur_reg.x, div_q[39:0], cur_reg.vx[31]);
                end
            end
            ST_MY_WAIT: begin
                if (div_done) begin
                    newy_reg <= sat_add(cur_reg.y, div_q[39:0], cur_reg.vy[31]);
                end
            end
            ST_M_WB: begin
                m_slot_reg   <= slot_ext[3:0];
                m_active_reg <= 1'b1;
                m_pos_x_reg  <= newx_reg;
                m_pos_y_reg  <= newy_reg;
                m_status_reg <= STAT_OK;
                m_last_reg   <= (i_reg == LAST_SLOT);
            end
            default: ;
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_slot      = m_slot_reg;
    assign m_active    = m_active_reg;
    assign m_out_pos_x = m_pos_x_reg;
    assign m_out_pos_y = m_pos_y_reg;
    assign m_status    = m_status_reg;
    assign m_last      = m_last_reg;

endmodule

// File: sim/nbody_gravity_euler_step_top_tb.sv
// Self-checking testbench for the n-body gravity Euler step block.
module nbody_gravity_euler_step_top_tb
    import nbeg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 3_000_000;

    // One expected result transaction.
    typedef struct {
        logic [3:0]  slot;
        logic        active;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic        status;
        logic        last;
    } body_report_t;

    // Tracks the body table and predicts the result transactions of each input.
    class body_table_sb;
        int          bx[SLOTS];
        int          by[SLOTS];
        int          bvx[SLOTS];
        int          bvy[SLOTS];
        int unsigned bmass[SLOTS];
        bit          used[SLOTS];
        logic [23:0] grav = GRAV_RESET;
        logic [9:0]  kpp = KPP_RESET;
        logic [15:0] dmin = DMIN_RESET;
        body_report_t awaited[$];
        int          errors;

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_GRAV: grav = val[23:0];
                REG_KPP:  kpp = val[9:0];
                REG_DMIN: dmin = val[15:0];
                default: ;
            endcase
        endfunction

        function int body_count();
            int n;
            n = 0;
            foreach (used[k]) n += used[k];
            return n;
        endfunction

        function longint unsigned mag64(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint signed_of(longint unsigned m, bit neg);
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function int sat32(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return int'(v);
        endfunction

        // Floor square root, one result bit per step.
        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // Velocity change of body i due to body j over one step.
        function void apply_pull(int i, int j, longint unsigned dt, longint unsigned kp,
                                 longint unsigned dm);
            longint px, py;
            longint unsigned ax, ay, r, acc, cx, cy;
            px = longint'(bx[j]) - longint'(bx[i]);
            py = longint'(by[j]) - longint'(by[i]);
            ax = (mag64(px) * kp) >> 16;
            ay = (mag64(py) * kp) >> 16;
            r = floor_sqrt(ax * ax + ay * ay);
            if (r < dm) r = dm;
            acc = ((longint'(grav) * longint'(bmass[j])) << 16) / (r * r);
            if (acc > 64'h7FFF_FFFF) acc = 64'h7FFF_FFFF;
            cx = acc * ax / r;
            cy = acc * ay / r;
            bvx[i] = sat32(longint'(bvx[i]) + signed_of((cx * dt) >> 16, px < 0));
            bvy[i] = sat32(longint'(bvy[i]) + signed_of((cy * dt) >> 16, py < 0));
        endfunction

        function int advance(int pos, int vel, longint unsigned dt, longint unsigned kp);
            longint unsigned m;
            m = (mag64(longint'(vel)) * dt) / (kp << 16);
            return sat32(longint'(pos) + signed_of(m, vel < 0));
        endfunction

        // Notes an accepted input transaction and queues its results.
        function void note_input(logic act, logic [23:0] dt, logic [31:0] px, logic [31:0] py,
                                 logic [31:0] vx, logic [31:0] vy, logic [19:0] mass);
            body_report_t e;
            longint unsigned kp, dm;
            int free;
            kp = (kpp == 0) ? 1 : kpp;
            dm = (dmin == 0) ? 1 : dmin;
            if (act == ACT_SPAWN) begin
                free = -1;
                for (int k = SLOTS - 1; k >= 0; k--) if (!used[k]) free = k;
                e = '{4'd0, 1'b0, 32'd0, 32'd0, STAT_FULL, 1'b1};
                if (free >= 0) begin
                    bx[free] = px; by[free] = py; bvx[free] = vx; bvy[free] = vy;
                    bmass[free] = 32'(mass);
                    used[free] = 1;
                    e = '{free[3:0], 1'b1, px, py, STAT_OK, 1'b1};
                end
                awaited.push_back(e);
                return;
            end
            for (int i = 0; i < SLOTS; i++)
                if (used[i])
                    for (int j = 0; j < SLOTS; j++)
                        if (j != i && used[j]) apply_pull(i, j, dt, kp, dm);
            for (int i = 0; i < SLOTS; i++) begin
                if (used[i]) begin
                    bx[i] = advance(bx[i], bvx[i], dt, kp);
                    by[i] = advance(by[i], bvy[i], dt, kp);
                end
                e.slot = i[3:0];
                e.active = used[i];
                e.pos_x = used[i] ? bx[i] : 0;
                e.pos_y = used[i] ? by[i] : 0;
                e.status = STAT_OK;
                e.last = (i == SLOTS - 1);
                awaited.push_back(e);
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch: %s got %h expected %h", what, got, want);
            errors++;
        endtask

        // Checks one accepted result transaction against the oldest expectation.
        task check_result(body_report_t got);
            body_report_t w;
            if (awaited.size() == 0) begin
                report("unexpected result, slot", 32'(got.slot), 32'd0);
                return;
            end
            w = awaited.pop_front();
            if (got.slot !== w.slot) report("slot", 32'(got.slot), 32'(w.slot));
            if (got.active !== w.active) report("active", 32'(got.active), 32'(w.active));
            if (got.pos_x !== w.pos_x) report("out_pos_x", got.pos_x, w.pos_x);
            if (got.pos_y !== w.pos_y) report("out_pos_y", got.pos_y, w.pos_y);
            if (got.status !== w.status) report("status", 32'(got.status), 32'(w.status));
            if (got.last !== w.last) report("last", 32'(got.last), 32'(w.last));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = ACT_TICK;
    logic [23:0] s_dt = '0;
    logic [31:0] s_in_pos_x = '0;
    logic [31:0] s_in_pos_y = '0;
    logic [31:0] s_in_vel_x = '0;
    logic [31:0] s_in_vel_y = '0;
    logic [19:0] s_in_mass = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_slot;
    logic        m_active;
    logic [31:0] m_out_pos_x;
    logic [31:0] m_out_pos_y;
    logic        m_status;
    logic        m_last;

    body_table_sb sb = new();
    int  cycles = 0;
    bit  quiet = 1'b0;
    int  hold_req = 0;

    nbody_gravity_euler_step_top DUT (.*);

    always #2 aclk = ~aclk;

    // Run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: checks transactions and applies random and long stalls.
    initial begin
        int stall;
        body_report_t got;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = '{m_slot, m_active, m_out_pos_x, m_out_pos_y, m_status, m_last};
                sb.check_result(got);
            end
            if (hold_req > 0) begin
                hold_req--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!quiet && aresetn && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(0, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Writes one configuration register through a setup and an access cycle.
    task cfg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // Offers one input transaction and waits for its acceptance.
    task send_item(logic act, logic [23:0] dt, logic [31:0] px, logic [31:0] py,
                   logic [31:0] vx, logic [31:0] vy, logic [19:0] mass);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act; s_dt <= dt;
        s_in_pos_x <= px; s_in_pos_y <= py;
        s_in_vel_x <= vx; s_in_vel_y <= vy; s_in_mass <= mass;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(act, dt, px, py, vx, vy, mass);
    endtask

    // Pauses the sender until every expected result has come back.
    task drain();
        s_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Either a full-range value or a small one near the origin.
    function logic [31:0] rand_word();
        if ($urandom_range(0, 2) == 0) return $urandom();
        return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endfunction

    task random_item();
        logic [23:0] dt;
        dt = ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                         : 24'($urandom_range(0, 24'h01_FFFF));
        if (sb.body_count() < 5 && $urandom_range(0, 2) == 0)
            send_item(ACT_SPAWN, 24'($urandom()), rand_word(), rand_word(), rand_word(),
                      rand_word(), 20'($urandom()));
        else
            send_item(ACT_TICK, dt, $urandom(), $urandom(), $urandom(), $urandom(),
                      20'($urandom()));
    endtask

    initial begin
        logic [31:0] grav_set[4] = '{32'd0, 32'hFF_FFFF, 32'd6674, 32'(GRAV_RESET)};
        logic [31:0] kpp_set[4]  = '{32'd1, 32'd1023, 32'd0, 32'(KPP_RESET)};
        logic [31:0] dmin_set[4] = '{32'd65535, 32'd1, 32'd0, 32'd300};

        // Reset.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, extreme bodies, coincident bodies, dt extremes.
        send_item(ACT_TICK, 24'hFF_FFFF, '0, '0, '0, '0, '0);
        send_item(ACT_SPAWN, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 20'hF_FFFF);
        send_item(ACT_SPAWN, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 20'd0);
        send_item(ACT_TICK, 24'd0, '0, '0, '0, '0, '0);
        send_item(ACT_TICK, 24'd1, '0, '0, '0, '0, '0);
        send_item(ACT_SPAWN, '0, 32'd0, 32'd0, 32'hFFFF_0000, 32'h0001_0000, 20'd1);
        send_item(ACT_TICK, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 20'hF_FFFF);
        send_item(ACT_TICK, 24'h01_0000, '0, '0, '0, '0, '0);

        // Long receiver hold, longer than a tick of the current table, while inputs
        // keep coming.
        hold_req = 3000;
        repeat (3) random_item();
        drain();

        // Random phases over several register settings.
        for (int ph = 0; ph < 4; ph++) begin
            cfg_write(REG_GRAV, grav_set[ph]);
            cfg_write(REG_KPP, kpp_set[ph]);
            cfg_write(REG_DMIN, dmin_set[ph]);
            quiet = (ph == 2);
            repeat (18) random_item();
            drain();
        end

        // Fill the table, overflow it, and tick it full, with no idling.
        quiet = 1'b1;
        while (sb.body_count() < SLOTS)
            send_item(ACT_SPAWN, '0, rand_word(), rand_word(), rand_word(), rand_word(),
                      20'($urandom()));
        send_item(ACT_SPAWN, '0, 32'h1234_5678, 32'h9ABC_DEF0, '1, '1, '1);
        send_item(ACT_TICK, 24'h00_8000, '0, '0, '0, '0, '0);
        send_item(ACT_SPAWN, '0, '0, '0, '0, '0, '0);
        s_valid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
